// ===== rtl/core/cqcf_pkg.sv =====
package cqcf_pkg;

    // default coordinate width, handed to the top-level parameter
    localparam int COORD_BITS_DEF = 12;

    // configuration port
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BOX_LEFT   = 3'd0,
        CFG_BOX_TOP    = 3'd1,
        CFG_BOX_RIGHT  = 3'd2,
        CFG_BOX_BOTTOM = 3'd3,
        CFG_DIAG_MODE  = 3'd4
    } t_cfg_idx;

    // corner regions: diagonal names, axis mode uses the same slots
    // (upper-left, upper-right, lower-right, lower-left)
    localparam int NUM_CORNERS = 4;

    typedef enum logic [1:0] {
        RGN_LEFT   = 2'd0,
        RGN_TOP    = 2'd1,
        RGN_RIGHT  = 2'd2,
        RGN_BOTTOM = 2'd3
    } t_region;

    // control that travels with a point through the pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } t_pt_ctl;

    typedef struct packed {
        logic    valid;
        logic    last;
        logic    hit;
        t_region region;
    } t_sort_ctl;

endpackage

// ===== rtl/core/cqcf_point_if.sv =====
interface cqcf_point_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  last_point;

    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink   (input valid, point_x, point_y, last_point, output ready);
    modport monitor (input valid, ready, point_x, point_y, last_point);
endinterface

// ===== rtl/core/cqcf_corner_if.sv =====
interface cqcf_corner_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] corner0_x;
    logic [COORD_BITS-1:0] corner0_y;
    logic [COORD_BITS-1:0] corner1_x;
    logic [COORD_BITS-1:0] corner1_y;
    logic [COORD_BITS-1:0] corner2_x;
    logic [COORD_BITS-1:0] corner2_y;
    logic [COORD_BITS-1:0] corner3_x;
    logic [COORD_BITS-1:0] corner3_y;

    modport source (
        output valid, corner0_x, corner0_y, corner1_x, corner1_y,
               corner2_x, corner2_y, corner3_x, corner3_y,
        input  ready
    );
    modport sink (
        input  valid, corner0_x, corner0_y, corner1_x, corner1_y,
               corner2_x, corner2_y, corner3_x, corner3_y,
        output ready
    );
    modport monitor (
        input valid, ready, corner0_x, corner0_y, corner1_x, corner1_y,
              corner2_x, corner2_y, corner3_x, corner3_y
    );
endinterface

// ===== rtl/core/cqcf_region_sort.sv =====
module cqcf_region_sort
    import cqcf_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_pt_ctl               i_ctl,
    input  logic [COORD_BITS-1:0] i_x,
    input  logic [COORD_BITS-1:0] i_y,
    input  logic [COORD_BITS-1:0] i_left,
    input  logic [COORD_BITS-1:0] i_top,
    input  logic [COORD_BITS-1:0] i_right,
    input  logic [COORD_BITS-1:0] i_bottom,
    input  logic                  i_diag,
    output t_sort_ctl             o_ctl,
    output logic [COORD_BITS+1:0] o_dx,
    output logic [COORD_BITS+1:0] o_dy
);
    localparam int N      = COORD_BITS;
    localparam int P_BITS = 2 * N + 2;
    localparam int S_BITS = 2 * N + 3;

    // stage a: box extents and the three diagonal products
    logic signed [N:0]        w, h, ydb, ydt, xdr;
    logic signed [P_BITS-1:0] n_p1, n_p2, n_p3;
    logic signed [P_BITS-1:0] r_p1, r_p2, r_p3;
    logic [N-1:0]             r_a_x, r_a_y;
    t_pt_ctl                  r_a_ctl;

    assign w   = $signed({1'b0, i_right})  - $signed({1'b0, i_left});
    assign h   = $signed({1'b0, i_bottom}) - $signed({1'b0, i_top});
    assign ydb = $signed({1'b0, i_y})      - $signed({1'b0, i_bottom});
    assign ydt = $signed({1'b0, i_y})      - $signed({1'b0, i_top});
    assign xdr = $signed({1'b0, i_x})      - $signed({1'b0, i_right});
    assign n_p1 = P_BITS'(w) * P_BITS'(ydb);
    assign n_p2 = P_BITS'(h) * P_BITS'(xdr);
    assign n_p3 = P_BITS'(w) * P_BITS'(ydt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else if (i_en) begin
            r_a_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1  <= n_p1;
            r_p2  <= n_p2;
            r_p3  <= n_p3;
            r_a_x <= i_x;
            r_a_y <= i_y;
        end
    end

    // stage b: diagonal sides
    logic [S_BITS-1:0] d1, d2;
    logic              gt1, lt1, gt2, lt2;

    assign d1  = {r_p1[P_BITS-1], r_p1} - {r_p2[P_BITS-1], r_p2};
    assign d2  = {r_p3[P_BITS-1], r_p3} + {r_p2[P_BITS-1], r_p2};
    assign lt1 = d1[S_BITS-1];
    assign gt1 = !d1[S_BITS-1] && (d1 != '0);
    assign lt2 = d2[S_BITS-1];
    assign gt2 = !d2[S_BITS-1] && (d2 != '0);

    // box centre for axis mode
    logic [N:0]   sum_lr, sum_tb;
    logic [N-1:0] hx, hy;
    logic         x_lt, x_gt, y_lt, y_gt;

    assign sum_lr = {1'b0, i_left} + {1'b0, i_right};
    assign sum_tb = {1'b0, i_top}  + {1'b0, i_bottom};
    assign hx     = sum_lr[N:1];
    assign hy     = sum_tb[N:1];
    assign x_lt   = r_a_x < hx;
    assign x_gt   = r_a_x > hx;
    assign y_lt   = r_a_y < hy;
    assign y_gt   = r_a_y > hy;

    // region pick and its doubled reference point
    logic         hit;
    t_region      region;
    logic [N:0]   ref_x, ref_y;

    always_comb begin
        hit    = 1'b1;
        region = RGN_LEFT;
        if (i_diag) begin
            if (!lt1 && gt2) begin
                region = RGN_TOP;
            end else if (gt1 && !gt2) begin
                region = RGN_RIGHT;
            end else if (!gt1 && lt2) begin
                region = RGN_BOTTOM;
            end else if (lt1 && !lt2) begin
                region = RGN_LEFT;
            end else begin
                hit = 1'b0;
            end
        end else begin
            if (x_lt && !y_gt) begin
                region = RGN_LEFT;
            end else if (!x_lt && y_lt) begin
                region = RGN_TOP;
            end else if (x_gt && !y_lt) begin
                region = RGN_RIGHT;
            end else if (!x_gt && y_gt) begin
                region = RGN_BOTTOM;
            end else begin
                hit = 1'b0;
            end
        end
    end

    always_comb begin
        ref_x = '0;
        ref_y = '0;
        if (i_diag) begin
            case (region)
                RGN_TOP:    begin ref_x = sum_lr;            ref_y = {i_top, 1'b0};    end
                RGN_RIGHT:  begin ref_x = {i_right, 1'b0};   ref_y = sum_tb;           end
                RGN_BOTTOM: begin ref_x = sum_lr;            ref_y = {i_bottom, 1'b0}; end
                default:    begin ref_x = {i_left, 1'b0};    ref_y = sum_tb;           end
            endcase
        end else begin
            case (region)
                RGN_TOP:    begin ref_x = {i_left, 1'b0};  ref_y = {i_bottom, 1'b0}; end
                RGN_RIGHT:  begin ref_x = {i_left, 1'b0};  ref_y = {i_top, 1'b0};    end
                RGN_BOTTOM: begin ref_x = {i_right, 1'b0}; ref_y = {i_top, 1'b0};    end
                default:    begin ref_x = {i_right, 1'b0}; ref_y = {i_bottom, 1'b0}; end
            endcase
        end
    end

    // stage b registers
    t_sort_ctl    r_b_ctl;
    logic [N+1:0] r_b_dx, r_b_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '0;
        end else if (i_en) begin
            r_b_ctl.valid  <= r_a_ctl.valid;
            r_b_ctl.last   <= r_a_ctl.last;
            r_b_ctl.hit    <= hit;
            r_b_ctl.region <= region;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_dx <= {1'b0, r_a_x, 1'b0} - {1'b0, ref_x};
            r_b_dy <= {1'b0, r_a_y, 1'b0} - {1'b0, ref_y};
        end
    end

    assign o_ctl = r_b_ctl;
    assign o_dx  = r_b_dx;
    assign o_dy  = r_b_dy;

endmodule

// ===== rtl/core/contour_quad_corner_finder.sv =====
// channel   | dir | modport | payload
// ----------+-----+---------+---------------------------------------------
// i_pt      | in  | sink    | point_x, point_y, last_point
// o_corner  | out | source  | corner0..3 x/y, one transaction per contour
// i_cfg_*   | in  | -       | box_left/top/right/bottom, diagonal_mode
//
// one point per cycle while no stall holds the pipeline; the best-point update is a
// compare-and-write per region, which sets that rate
// five-register pipeline: input, sort stage a, sort stage b, update stage, result register
// reset is synchronous and clears control, config and the kept corners
// a held result stalls the pipeline only when a second last point reaches
// the update stage; other points keep flowing
module contour_quad_corner_finder
    import cqcf_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [COORD_BITS-1:0]   i_cfg_data,
    cqcf_point_if.sink              i_pt,
    cqcf_corner_if.source           o_corner
);
    localparam int N         = COORD_BITS;
    localparam int SQ_BITS   = 2 * N + 2;
    localparam int DIST_BITS = 2 * N + 4;
    localparam int PROD_BITS = 2 * N + 4;

    // configuration registers
    logic [N-1:0] r_left, r_top, r_right, r_bottom;
    logic         r_diag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_top    <= '0;
            r_right  <= '0;
            r_bottom <= '0;
            r_diag   <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BOX_LEFT:   r_left   <= i_cfg_data;
                CFG_BOX_TOP:    r_top    <= i_cfg_data;
                CFG_BOX_RIGHT:  r_right  <= i_cfg_data;
                CFG_BOX_BOTTOM: r_bottom <= i_cfg_data;
                CFG_DIAG_MODE:  r_diag   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline advance: hold only when a last point meets a held result
    t_sort_ctl r_c_ctl;
    logic      r_out_valid;
    logic      stall, en;

    assign stall      = r_c_ctl.valid && r_c_ctl.last && r_out_valid && !o_corner.ready;
    assign en         = !stall;
    assign i_pt.ready = en;

    // input register
    t_pt_ctl      r_in_ctl;
    logic [N-1:0] r_in_x, r_in_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ctl <= '0;
        end else if (en) begin
            r_in_ctl.valid <= i_pt.valid;
            r_in_ctl.last  <= i_pt.last_point;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_x <= i_pt.point_x;
            r_in_y <= i_pt.point_y;
        end
    end

    // region sort and reference offsets
    t_sort_ctl    sort_ctl;
    logic [N+1:0] sort_dx, sort_dy;

    cqcf_region_sort #(
        .COORD_BITS (COORD_BITS)
    ) u_sort (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_ctl    (r_in_ctl),
        .i_x      (r_in_x),
        .i_y      (r_in_y),
        .i_left   (r_left),
        .i_top    (r_top),
        .i_right  (r_right),
        .i_bottom (r_bottom),
        .i_diag   (r_diag),
        .o_ctl    (sort_ctl),
        .o_dx     (sort_dx),
        .o_dy     (sort_dy)
    );

    // squares of the offsets
    logic signed [N+1:0]     sdx, sdy;
    logic signed [2*N+3:0]   prod_x, prod_y;
    logic [SQ_BITS-1:0]      r_sqx, r_sqy;

    assign sdx    = $signed(sort_dx);
    assign sdy    = $signed(sort_dy);
    assign prod_x = PROD_BITS'(sdx) * PROD_BITS'(sdx);
    assign prod_y = PROD_BITS'(sdy) * PROD_BITS'(sdy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_ctl <= '0;
        end else if (en) begin
            r_c_ctl <= sort_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sqx <= prod_x[SQ_BITS-1:0];
            r_sqy <= prod_y[SQ_BITS-1:0];
        end
    end

    // point delay line alongside the sort stages
    logic [N-1:0] u_sort_x, u_sort_y;
    logic [N-1:0] r_a_x, r_a_y;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_x <= r_in_x;
            r_a_y <= r_in_y;
        end
    end

    assign u_sort_x = r_a_x;
    assign u_sort_y = r_a_y;

    // point coordinates at the update stage
    logic [N-1:0] r_c_x, r_c_y, r_b_x, r_b_y;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_x <= u_sort_x;
            r_b_y <= u_sort_y;
            r_c_x <= r_b_x;
            r_c_y <= r_b_y;
        end
    end

    // best-point update per region
    logic [N-1:0]         r_best_x [NUM_CORNERS];
    logic [N-1:0]         r_best_y [NUM_CORNERS];
    logic [DIST_BITS-1:0] r_best_d [NUM_CORNERS];
    logic [N-1:0]         n_best_x [NUM_CORNERS];
    logic [N-1:0]         n_best_y [NUM_CORNERS];
    logic [DIST_BITS-1:0] n_best_d [NUM_CORNERS];
    logic [DIST_BITS-1:0] pt_dist;
    logic                 upd;

    assign pt_dist = {2'b00, r_sqx} + {2'b00, r_sqy};
    assign upd     = r_c_ctl.valid && r_c_ctl.hit && (pt_dist > r_best_d[r_c_ctl.region]);

    always_comb begin
        for (int k = 0; k < NUM_CORNERS; k++) begin
            n_best_x[k] = r_best_x[k];
            n_best_y[k] = r_best_y[k];
            n_best_d[k] = r_best_d[k];
        end
        if (upd) begin
            n_best_x[r_c_ctl.region] = r_c_x;
            n_best_y[r_c_ctl.region] = r_c_y;
            n_best_d[r_c_ctl.region] = pt_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CORNERS; k++) begin
                r_best_x[k] <= '0;
                r_best_y[k] <= '0;
                r_best_d[k] <= '0;
            end
        end else if (en && r_c_ctl.valid) begin
            for (int k = 0; k < NUM_CORNERS; k++) begin
                if (r_c_ctl.last) begin
                    r_best_x[k] <= '0;
                    r_best_y[k] <= '0;
                    r_best_d[k] <= '0;
                end else begin
                    r_best_x[k] <= n_best_x[k];
                    r_best_y[k] <= n_best_y[k];
                    r_best_d[k] <= n_best_d[k];
                end
            end
        end
    end

    // result register
    logic [N-1:0] r_out_x [NUM_CORNERS];
    logic [N-1:0] r_out_y [NUM_CORNERS];
    logic         take_last;

    assign take_last = en && r_c_ctl.valid && r_c_ctl.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take_last) begin
            r_out_valid <= 1'b1;
        end else if (o_corner.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_last) begin
            for (int k = 0; k < NUM_CORNERS; k++) begin
                r_out_x[k] <= n_best_x[k];
                r_out_y[k] <= n_best_y[k];
            end
        end
    end

    assign o_corner.valid     = r_out_valid;
    assign o_corner.corner0_x = r_out_x[0];
    assign o_corner.corner0_y = r_out_y[0];
    assign o_corner.corner1_x = r_out_x[1];
    assign o_corner.corner1_y = r_out_y[1];
    assign o_corner.corner2_x = r_out_x[2];
    assign o_corner.corner2_y = r_out_y[2];
    assign o_corner.corner3_x = r_out_x[3];
    assign o_corner.corner3_y = r_out_y[3];

endmodule

// ===== rtl/core/cqcf_checker.sv =====
module cqcf_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    cqcf_point_if.sink     i_pt,
    cqcf_corner_if.source  o_corner
);

    // a result waiting on the sink stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_corner.valid && !o_corner.ready |=> o_corner.valid)
        else $error("result dropped while stalled");

    // a held result keeps its corners
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_corner.valid && !o_corner.ready |=>
            $stable(o_corner.corner0_x) && $stable(o_corner.corner0_y) &&
            $stable(o_corner.corner1_x) && $stable(o_corner.corner1_y) &&
            $stable(o_corner.corner2_x) && $stable(o_corner.corner2_y) &&
            $stable(o_corner.corner3_x) && $stable(o_corner.corner3_y))
        else $error("held result changed");

    // the point side only backs up behind a stalled result
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pt.ready |-> o_corner.valid && !o_corner.ready)
        else $error("point channel stalled without a held result");

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_corner.valid)
        else $error("result valid after reset");

endmodule

bind contour_quad_corner_finder cqcf_checker u_cqcf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_pt     (i_pt),
    .o_corner (o_corner)
);

// ===== dv/tb_contour_quad_corner_finder.sv =====
module tb_contour_quad_corner_finder;
    timeunit 1ns;
    timeprecision 1ps;

    import cqcf_pkg::*;

    localparam int CB             = COORD_BITS_DEF;
    localparam int SCORE_BITS     = 2 * CB + 4;
    localparam int RANDOM_POINTS  = 650;
    localparam int DRAIN_CYCLES   = 12;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef logic [CB-1:0] t_coord;

    localparam t_coord CMAX = '1;

    typedef struct packed {
        logic [NUM_CORNERS-1:0][CB-1:0] x;
        logic [NUM_CORNERS-1:0][CB-1:0] y;
    } t_corners;

    typedef enum logic {ROW_POINT, ROW_BOX} t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_coord    x;
        t_coord    y;
        logic      last;
        logic      has_lit;
        t_corners  lit;
        t_coord    left;
        t_coord    top;
        t_coord    right;
        t_coord    bottom;
        logic      diag;
    } t_row;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    t_coord i_cfg_data;

    cqcf_point_if  #(.COORD_BITS(CB)) pt_if ();
    cqcf_corner_if #(.COORD_BITS(CB)) corner_if ();

    contour_quad_corner_finder #(.COORD_BITS(CB)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pt       (pt_if),
        .o_corner   (corner_if)
    );

    // box registers as the block should hold them
    t_coord cfg_left, cfg_top, cfg_right, cfg_bottom;
    logic   cfg_diag;

    // farthest point kept per region
    t_coord                kept_x[NUM_CORNERS];
    t_coord                kept_y[NUM_CORNERS];
    logic [SCORE_BITS-1:0] kept_score[NUM_CORNERS];

    t_corners corners_due[$];
    t_row     stim_rows[$];

    // sideband that travels with the offered point: typed-in expectation
    logic     lit_on;
    t_corners lit_corners;

    t_coord prev_x, prev_y;
    int     points_sent;
    int     corners_seen;
    int     boxes_written;
    int     n_fail;
    logic   squeeze_req;
    logic   squeeze_done;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // squared distance in doubled coordinates, cut to the score width
    function automatic logic [SCORE_BITS-1:0] doubled_sq_dist(longint ax, longint ay,
                                                              longint bx, longint by);
        longint dx, dy, s;
        dx = ax - bx;
        dy = ay - by;
        s  = dx * dx + dy * dy;
        return s[SCORE_BITS-1:0];
    endfunction

    // sort one point into its region, keep it if farther, emit corners on last
    function automatic bit fold_point_into_corners(t_coord px, t_coord py, logic last,
                                                   output t_corners res);
        longint l, t, r, b, x, y, w, h, s1, s2, hx, hy, rx, ry;
        logic [SCORE_BITS-1:0] score;
        t_region rgn;
        logic hit;
        l = longint'(cfg_left);
        t = longint'(cfg_top);
        r = longint'(cfg_right);
        b = longint'(cfg_bottom);
        x = longint'(px);
        y = longint'(py);
        hit = 1'b1;
        rgn = RGN_LEFT;
        rx = 0;
        ry = 0;
        res = '0;
        if (cfg_diag) begin
            w  = r - l;
            h  = b - t;
            s1 = w * (y - b) - h * (x - r);
            s2 = w * (y - t) + h * (x - r);
            if (s1 >= 0 && s2 > 0) begin
                rgn = RGN_TOP;    rx = l + r; ry = 2 * t;
            end else if (s1 > 0 && s2 <= 0) begin
                rgn = RGN_RIGHT;  rx = 2 * r; ry = t + b;
            end else if (s1 <= 0 && s2 < 0) begin
                rgn = RGN_BOTTOM; rx = l + r; ry = 2 * b;
            end else if (s1 < 0 && s2 >= 0) begin
                rgn = RGN_LEFT;   rx = 2 * l; ry = t + b;
            end else begin
                hit = 1'b0;
            end
        end else begin
            hx = (l + r) / 2;
            hy = (t + b) / 2;
            if (x < hx && y <= hy) begin
                rgn = RGN_LEFT;   rx = 2 * r; ry = 2 * b;
            end else if (x >= hx && y < hy) begin
                rgn = RGN_TOP;    rx = 2 * l; ry = 2 * b;
            end else if (x > hx && y >= hy) begin
                rgn = RGN_RIGHT;  rx = 2 * l; ry = 2 * t;
            end else if (x <= hx && y > hy) begin
                rgn = RGN_BOTTOM; rx = 2 * r; ry = 2 * t;
            end else begin
                hit = 1'b0;
            end
        end
        // strictly farther only: ties and zero scores keep what is there
        if (hit) begin
            score = doubled_sq_dist(2 * x, 2 * y, rx, ry);
            if (score > kept_score[rgn]) begin
                kept_score[rgn] = score;
                kept_x[rgn]     = px;
                kept_y[rgn]     = py;
            end
        end
        if (!last)
            return 1'b0;
        for (int k = 0; k < NUM_CORNERS; k++) begin
            res.x[k]      = kept_x[k];
            res.y[k]      = kept_y[k];
            kept_x[k]     = '0;
            kept_y[k]     = '0;
            kept_score[k] = '0;
        end
        return 1'b1;
    endfunction

    // directed table helpers
    function automatic t_corners corner_set(t_coord x0, t_coord y0, t_coord x1, t_coord y1,
                                            t_coord x2, t_coord y2, t_coord x3, t_coord y3);
        t_corners c;
        c.x[0] = x0; c.y[0] = y0;
        c.x[1] = x1; c.y[1] = y1;
        c.x[2] = x2; c.y[2] = y2;
        c.x[3] = x3; c.y[3] = y3;
        return c;
    endfunction

    function automatic void add_point_lit(t_coord x, t_coord y, logic last, logic has_lit,
                                          t_corners lit);
        t_row row;
        row.kind    = ROW_POINT;
        row.x       = x;
        row.y       = y;
        row.last    = last;
        row.has_lit = has_lit;
        row.lit     = lit;
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    function automatic void add_point(t_coord x, t_coord y, logic last);
        add_point_lit(x, y, last, 1'b0, '0);
    endfunction

    function automatic void add_box(t_coord l, t_coord t, t_coord r, t_coord b, logic diag);
        t_row row;
        row.kind    = ROW_BOX;
        row.has_lit = 1'b0;
        row.left    = l;
        row.top     = t;
        row.right   = r;
        row.bottom  = b;
        row.diag    = diag;
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    function automatic void build_directed_rows();
        t_corners zero;
        zero = '0;
        // reset box is all zero: only the origin sits on both dividers
        add_point_lit('0, '0, 1'b1, 1'b1, zero);
        add_point_lit(CMAX, CMAX, 1'b1, 1'b1, corner_set('0, '0, '0, '0, CMAX, CMAX, '0, '0));
        add_point(CMAX, '0, 1'b0);
        add_point_lit('0, CMAX, 1'b1, 1'b1, corner_set('0, '0, '0, '0, CMAX, '0, '0, CMAX));
        // square box, diagonal regions: center skipped, mirrored tie, repeated point
        add_box(12'd100, 12'd100, 12'd300, 12'd300, 1'b1);
        add_point(12'd200, 12'd200, 1'b0);
        add_point(12'd50, 12'd190, 1'b0);
        add_point(12'd50, 12'd210, 1'b0);
        add_point(12'd200, 12'd20, 1'b0);
        add_point(12'd200, 12'd20, 1'b0);
        add_point(12'd380, 12'd200, 1'b0);
        add_point(12'd200, 12'd350, 1'b1);
        // full-range box, quadrants: one extreme point per quadrant
        add_box('0, '0, CMAX, CMAX, 1'b0);
        add_point(12'd2047, 12'd2047, 1'b0);
        add_point('0, '0, 1'b0);
        add_point(CMAX, '0, 1'b0);
        add_point(CMAX, CMAX, 1'b0);
        add_point_lit('0, CMAX, 1'b1, 1'b1,
                      corner_set('0, '0, CMAX, '0, CMAX, CMAX, '0, CMAX));
        // inverted box, quadrants: each point lands on its own reference
        add_box(CMAX, CMAX, '0, '0, 1'b0);
        add_point('0, '0, 1'b0);
        add_point_lit(CMAX, CMAX, 1'b1, 1'b1, zero);
        // inverted box, diagonal regions
        add_box(12'd300, 12'd300, 12'd100, 12'd100, 1'b1);
        add_point(12'd50, 12'd60, 1'b0);
        add_point(12'd350, 12'd20, 1'b0);
        add_point(CMAX, CMAX, 1'b1);
        // box rewritten while a contour is open
        add_point(12'd10, 12'd4000, 1'b0);
        add_box(12'd1000, 12'd500, 12'd3000, 12'd3500, 1'b0);
        add_point(12'd3000, 12'd100, 1'b1);
    endfunction

    // gap length: mostly short, a few long
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(99, 0);
        if (sel < 70)
            return $urandom_range(3, 1);
        else if (sel < 95)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // random point around the current box, with divider points and repeats
    function automatic void pick_point(output t_coord x, output t_coord y);
        int lo_x, hi_x, lo_y, hi_y, mid_x, mid_y, sel;
        lo_x  = (cfg_left < cfg_right) ? int'(cfg_left) : int'(cfg_right);
        hi_x  = (cfg_left < cfg_right) ? int'(cfg_right) : int'(cfg_left);
        lo_y  = (cfg_top < cfg_bottom) ? int'(cfg_top) : int'(cfg_bottom);
        hi_y  = (cfg_top < cfg_bottom) ? int'(cfg_bottom) : int'(cfg_top);
        lo_x  = (lo_x > 8) ? lo_x - 8 : 0;
        lo_y  = (lo_y > 8) ? lo_y - 8 : 0;
        hi_x  = (hi_x < 4087) ? hi_x + 8 : 4095;
        hi_y  = (hi_y < 4087) ? hi_y + 8 : 4095;
        mid_x = (int'(cfg_left) + int'(cfg_right)) / 2;
        mid_y = (int'(cfg_top) + int'(cfg_bottom)) / 2;
        sel   = $urandom_range(99, 0);
        if (sel < 50) begin
            x = t_coord'($urandom_range(hi_x, lo_x));
            y = t_coord'($urandom_range(hi_y, lo_y));
        end else if (sel < 65) begin
            x = t_coord'($urandom);
            y = t_coord'($urandom);
        end else if (sel < 75) begin
            case ($urandom_range(5, 0))
                0:       begin x = t_coord'(mid_x); y = t_coord'(mid_y); end
                1:       begin x = cfg_left;        y = cfg_top;         end
                2:       begin x = cfg_right;       y = cfg_bottom;      end
                3:       begin x = cfg_right;       y = cfg_top;         end
                4:       begin x = cfg_left;        y = cfg_bottom;      end
                default: begin x = t_coord'(mid_x); y = cfg_top;         end
            endcase
        end else if (sel < 90) begin
            x = prev_x;
            y = prev_y;
        end else begin
            x = $urandom_range(1, 0) ? CMAX : '0;
            y = $urandom_range(1, 0) ? CMAX : '0;
        end
        prev_x = x;
        prev_y = y;
    endfunction

    // offer one point after an optional gap, return at its accepting edge
    task automatic offer_point(t_coord x, t_coord y, logic last, logic has_lit, t_corners lit,
                               int gap);
        if (gap > 0) begin
            pt_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pt_if.valid      <= 1'b1;
        pt_if.point_x    <= x;
        pt_if.point_y    <= y;
        pt_if.last_point <= last;
        lit_on           <= has_lit;
        lit_corners      <= lit;
        @(posedge i_clk);
        while (!pt_if.ready) @(posedge i_clk);
        points_sent++;
    endtask

    // let every expected transaction arrive and the pipeline empty
    task automatic wait_idle();
        pt_if.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (corners_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, t_coord value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    task automatic write_box(t_coord l, t_coord t, t_coord r, t_coord b, logic diag);
        wait_idle();
        write_reg(CFG_BOX_LEFT, l);
        write_reg(CFG_BOX_TOP, t);
        write_reg(CFG_BOX_RIGHT, r);
        write_reg(CFG_BOX_BOTTOM, b);
        write_reg(CFG_DIAG_MODE, t_coord'(diag));
        i_cfg_we   <= 1'b0;
        cfg_left   = l;
        cfg_top    = t;
        cfg_right  = r;
        cfg_bottom = b;
        cfg_diag   = diag;
        boxes_written++;
    endtask

    // one box setting, then a run of contours; squeeze sends short contours back to back
    task automatic run_phase(logic squeeze);
        int     n_contours, len, idle_pct, base, span_x, span_y;
        t_coord x, y, l, t;
        case ($urandom_range(9, 0))
            0: write_box('0, '0, CMAX, CMAX, 1'(($urandom_range(1, 0))));
            1: write_box(t_coord'($urandom), t_coord'($urandom), t_coord'($urandom),
                         t_coord'($urandom), 1'(($urandom_range(1, 0))));
            2: begin
                l = t_coord'($urandom_range(4000, 0));
                t = t_coord'($urandom_range(4000, 0));
                write_box(l, t, l + t_coord'($urandom_range(3, 1)),
                          t + t_coord'($urandom_range(3, 1)), 1'(($urandom_range(1, 0))));
            end
            default: begin
                base   = $urandom_range(3000, 0);
                span_x = $urandom_range(4095 - base, 1);
                l      = t_coord'(base);
                base   = $urandom_range(3000, 0);
                span_y = $urandom_range(4095 - base, 1);
                t      = t_coord'(base);
                write_box(l, t, l + t_coord'(span_x), t + t_coord'(span_y),
                          1'(($urandom_range(1, 0))));
            end
        endcase
        n_contours = squeeze ? 60 : $urandom_range(8, 2);
        idle_pct   = (squeeze || $urandom_range(2, 0) == 0) ? 0 : 40;
        if (squeeze)
            squeeze_req = 1'b1;
        for (int c = 0; c < n_contours; c++) begin
            if (squeeze)
                len = $urandom_range(3, 1);
            else
                len = ($urandom_range(9, 0) == 0) ? 1 : $urandom_range(24, 2);
            for (int i = 0; i < len; i++) begin
                pick_point(x, y);
                offer_point(x, y, i == len - 1, 1'b0, '0,
                            ($urandom_range(99, 0) < idle_pct) ? pick_gap() : 0);
            end
        end
        // sometimes leave a contour open across the next box write
        if (!squeeze && $urandom_range(3, 0) == 0) begin
            len = $urandom_range(5, 1);
            for (int i = 0; i < len; i++) begin
                pick_point(x, y);
                offer_point(x, y, 1'b0, 1'b0, '0, 0);
            end
        end
    endtask

    // input monitor: predict on every accepted point
    always @(posedge i_clk) begin : point_mon
        t_corners predicted;
        if (i_rst_n && pt_if.valid && pt_if.ready) begin
            if (fold_point_into_corners(pt_if.point_x, pt_if.point_y, pt_if.last_point,
                                        predicted)) begin
                if (lit_on)
                    predicted = lit_corners;
                corners_due.insert(corners_due.size(), predicted);
            end
        end
    end

    // output monitor: compare each corner transaction with the oldest expectation
    always @(posedge i_clk) begin : corner_mon
        t_corners got, want;
        if (i_rst_n && corner_if.valid && corner_if.ready) begin
            got.x[0] = corner_if.corner0_x; got.y[0] = corner_if.corner0_y;
            got.x[1] = corner_if.corner1_x; got.y[1] = corner_if.corner1_y;
            got.x[2] = corner_if.corner2_x; got.y[2] = corner_if.corner2_y;
            got.x[3] = corner_if.corner3_x; got.y[3] = corner_if.corner3_y;
            corners_seen++;
            if (corners_due.size() == 0) begin
                $error("corner transaction with no contour pending");
                n_fail++;
            end else begin
                want = corners_due.pop_front();
                for (int k = 0; k < NUM_CORNERS; k++) begin
                    if (got.x[k] !== want.x[k]) begin
                        $error("corner%0d_x expected %0d actual %0d", k, want.x[k], got.x[k]);
                        n_fail++;
                    end
                    if (got.y[k] !== want.y[k]) begin
                        $error("corner%0d_y expected %0d actual %0d", k, want.y[k], got.y[k]);
                        n_fail++;
                    end
                end
            end
        end
    end

    // receiver: random stalls, quiet stretches, one long hold-off
    initial begin : corner_sink
        int stall, run;
        stall = 0;
        run   = 0;
        corner_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (squeeze_req && !squeeze_done) begin
                squeeze_done = 1'b1;
                stall        = HOLD_CYCLES;
            end
            if (stall > 0) begin
                corner_if.ready <= 1'b0;
                stall--;
            end else begin
                corner_if.ready <= 1'b1;
                if (run > 0) begin
                    run--;
                end else if ($urandom_range(3, 0) == 0) begin
                    run = $urandom_range(150, 50);
                end else begin
                    stall = pick_gap();
                    run   = $urandom_range(12, 0);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((pt_if.valid && pt_if.ready) || (corner_if.valid && corner_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_contour_quad_corner_finder NOT OK");
        $finish;
    end

    // stimulus: directed table, then random box settings and contours
    initial begin : stimulus
        int   phase_no, random_start;
        t_row row;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= CFG_BOX_LEFT;
        i_cfg_data       <= '0;
        pt_if.valid      <= 1'b0;
        pt_if.point_x    <= '0;
        pt_if.point_y    <= '0;
        pt_if.last_point <= 1'b0;
        lit_on           <= 1'b0;
        lit_corners      <= '0;
        cfg_left         = '0;
        cfg_top          = '0;
        cfg_right        = '0;
        cfg_bottom       = '0;
        cfg_diag         = 1'b0;
        prev_x           = '0;
        prev_y           = '0;
        points_sent      = 0;
        corners_seen     = 0;
        boxes_written    = 0;
        n_fail           = 0;
        squeeze_req      = 1'b0;
        squeeze_done     = 1'b0;
        for (int k = 0; k < NUM_CORNERS; k++) begin
            kept_x[k]     = '0;
            kept_y[k]     = '0;
            kept_score[k] = '0;
        end
        build_directed_rows();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[i]) begin
            row = stim_rows[i];
            if (row.kind == ROW_BOX)
                write_box(row.left, row.top, row.right, row.bottom, row.diag);
            else
                offer_point(row.x, row.y, row.last, row.has_lit, row.lit,
                            $urandom_range(1, 0) ? pick_gap() : 0);
        end

        random_start = points_sent;
        phase_no     = 0;
        while (points_sent - random_start < RANDOM_POINTS) begin
            run_phase(phase_no == 2);
            phase_no++;
        end
        wait_idle();

        $display("covered %0d points, %0d corner sets, %0d box settings in both region modes",
                 points_sent, corners_seen, boxes_written);
        if (n_fail == 0)
            $display("tb_contour_quad_corner_finder OK");
        else
            $display("tb_contour_quad_corner_finder NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/cqcf_pkg.sv
rtl/core/cqcf_point_if.sv
rtl/core/cqcf_corner_if.sv
rtl/core/cqcf_region_sort.sv
rtl/core/contour_quad_corner_finder.sv
rtl/core/cqcf_checker.sv
dv/tb_contour_quad_corner_finder.sv
